// ----- sv/msd_pkg.sv -----
package msd_pkg;

  localparam int LANES = 32;
  localparam int COUNT_W = 6;
  localparam int THR_W = 5;
  localparam int CHAN_W = 6;
  localparam int LANE_IDX_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  // Operation codes of an input word.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 5'd3;

  // Status of one channel: state after the current word, flags as held before it.
  typedef struct packed {
    logic state;
    logic rise;
    logic change;
  } chan_stat_t;

  typedef struct packed {
    logic [LANES-1:0] states;
    logic chan_state;
    logic chan_rise_event;
    logic chan_change_event;
  } result_t;

endpackage

// ----- sv/msd_if.sv -----
interface msd_req_if;
  import msd_pkg::*;

  logic valid;
  logic ready;
  logic op;
  logic [LANES-1:0] levels;
  logic [CHAN_W-1:0] channel;

  modport source (output valid, output op, output levels, output channel, input ready);
  modport sink (input valid, input op, input levels, input channel, output ready);
endinterface

interface msd_rsp_if;
  import msd_pkg::*;

  logic valid;
  logic ready;
  logic [LANES-1:0] states;
  logic chan_state;
  logic chan_rise_event;
  logic chan_change_event;

  modport source (output valid, output states, output chan_state, output chan_rise_event,
                  output chan_change_event, input ready);
  modport sink (input valid, input states, input chan_state, input chan_rise_event,
                input chan_change_event, output ready);
endinterface

// ----- sv/msd_chan_cell.sv -----
module msd_chan_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick,
  input  logic                      clr,
  input  logic                      act,
  input  logic                      bypass,
  input  logic [msd_pkg::THR_W-1:0] thr,
  output msd_pkg::chan_stat_t       stat
);
  import msd_pkg::*;

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] thr_ext;
  logic last;
  logic rise;
  logic change;
  logic rise_set;

  assign thr_ext = {1'b0, thr};

  // The counter saturates one past the threshold and clears when inactive.
  always_comb begin
    if (!act) begin
      count_next = '0;
    end else if (count <= thr_ext) begin
      count_next = count + COUNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  assign rise_set = bypass ? (act && !last) : (count_next == thr_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      last <= 1'b0;
      rise <= 1'b0;
      change <= 1'b0;
    end else if (tick) begin
      count <= count_next;
      last <= act;
      rise <= rise | rise_set;
      change <= change | (act != last);
    end else if (clr) begin
      rise <= 1'b0;
      change <= 1'b0;
    end
  end

  always_comb begin
    if (bypass) begin
      stat.state = tick ? act : last;
    end else begin
      stat.state = (tick ? count_next : count) >= thr_ext;
    end
    stat.rise = rise;
    stat.change = change;
  end

endmodule

// ----- sv/msd_out_buf.sv -----
module msd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  msd_pkg::result_t   push_data,
  output logic               space,
  msd_rsp_if.source          rsp
);
  import msd_pkg::*;

  logic main_valid;
  result_t main_data;
  logic skid_valid;
  result_t skid_data;
  logic pop;

  assign space = !skid_valid;
  assign pop = main_valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign rsp.valid = main_valid;
  assign rsp.states = main_data.states;
  assign rsp.chan_state = main_data.chan_state;
  assign rsp.chan_rise_event = main_data.chan_rise_event;
  assign rsp.chan_change_event = main_data.chan_change_event;

endmodule

// ----- sv/multi_switch_debouncer.sv -----
// Debouncer for up to 32 switch channels. Each input word is either a sample
// tick carrying the raw levels of all channels or a read of one channel. On a
// tick every channel is updated at once: its level is inverted where
// active_low_mask is set, a per-channel counter counts consecutive active
// ticks up to one past debounce_threshold and clears on an inactive tick, and
// the debounced state is high once the count has reached the threshold (a
// threshold of zero acts as one). Channels marked in bypass_mask follow the
// polarity-corrected level directly. Each channel keeps a sticky rise flag,
// set when its state becomes active, and a sticky change flag, set on any
// level change; a read returns the channel's state and both flags and then
// clears the flags, while a read of a channel at or above CHANNELS returns
// zeros and clears nothing. Every word produces exactly one result word that
// also carries the debounced state of all channels. The block takes one word
// per clock cycle while the output stage has room; the result is registered in
// a two-entry output stage, which can hold one more word while a result waits
// to be taken. Configuration registers are written through the cfg_we port and
// should only be changed while no word is in flight.
module multi_switch_debouncer #(
  parameter int CHANNELS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data,
  msd_req_if.sink                        req,
  msd_rsp_if.source                      rsp
);
  import msd_pkg::*;

  logic [LANES-1:0] active_low_mask;
  logic [LANES-1:0] bypass_mask;
  logic [THR_W-1:0] debounce_threshold;

  logic [THR_W-1:0] thr_eff;
  logic [LANES-1:0] data;
  logic accept;
  logic tick;
  logic read_ok;
  logic [LANE_IDX_W-1:0] lane;
  logic space;
  chan_stat_t stat [LANES];
  logic [LANES-1:0] states_vec;
  logic [LANES-1:0] rise_vec;
  logic [LANES-1:0] change_vec;
  result_t result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_low_mask <= '0;
      bypass_mask <= '0;
      debounce_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LOW: active_low_mask <= cfg_data;
        REG_BYPASS: bypass_mask <= cfg_data;
        REG_THRESHOLD: debounce_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign thr_eff = (debounce_threshold == '0) ? THR_W'(1) : debounce_threshold;

  // A new word is taken whenever the output stage has room for its result.
  assign req.ready = space;
  assign accept = req.valid && space;
  assign tick = accept && (req.op == OP_TICK);
  assign read_ok = accept && (req.op == OP_READ) && (req.channel < CHAN_W'(CHANNELS));
  assign lane = req.channel[LANE_IDX_W-1:0];
  assign data = req.levels ^ active_low_mask;

  // One cell per implemented channel; unused lanes report all zeros.
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < CHANNELS) begin : g_cell
      msd_chan_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .tick  (tick),
        .clr   (read_ok && (lane == LANE_IDX_W'(i))),
        .act   (data[i]),
        .bypass(bypass_mask[i]),
        .thr   (thr_eff),
        .stat  (stat[i])
      );
    end else begin : g_unused
      assign stat[i] = '0;
    end
    assign states_vec[i] = stat[i].state;
    assign rise_vec[i] = stat[i].rise;
    assign change_vec[i] = stat[i].change;
  end

  // The flags reported on a read are the values before this read clears them.
  always_comb begin
    result.states = states_vec;
    result.chan_state = read_ok && states_vec[lane];
    result.chan_rise_event = read_ok && rise_vec[lane];
    result.chan_change_event = read_ok && change_vec[lane];
  end

  msd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(result),
    .space    (space),
    .rsp      (rsp)
  );

endmodule

// ----- verif/multi_switch_debouncer_tb.sv -----
`timescale 1ns / 1ps

module multi_switch_debouncer_tb;
  import msd_pkg::*;

  // A stimulus row either carries one input word or one register write.
  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic                  op;
    logic [LANES-1:0]      levels;
    logic [CHAN_W-1:0]     channel;
    bit                    typed;
    result_t               want;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  msd_req_if req_ch ();
  msd_rsp_if rsp_ch ();

  multi_switch_debouncer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the block's registers and per-channel state. It is
  // advanced once for every word the block accepts, in acceptance order.
  logic [LANES-1:0]   act_low_model;
  logic [LANES-1:0]   bypass_model;
  logic [THR_W-1:0]   thr_model;
  logic [COUNT_W-1:0] run_length [LANES];
  logic [LANES-1:0]   rise_model;
  logic [LANES-1:0]   change_model;
  logic [LANES-1:0]   last_active;

  // Results still owed by the block, oldest first.
  result_t   pending_results [$];
  stim_row_t stim_rows [$];

  int  mismatch_count = 0;
  int  results_checked = 0;
  int  tick_count = 0;
  int  read_count = 0;
  int  setting_count = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Debounced state of every channel as the block should report it now.
  // Bypass channels show their last polarity-corrected level; the others
  // are on once their run of active ticks has reached the threshold.
  function automatic logic [LANES-1:0] debounced_states();
    logic [LANES-1:0]   st;
    logic [COUNT_W-1:0] thr;
    thr = (thr_model == '0) ? COUNT_W'(1) : COUNT_W'(thr_model);
    for (int i = 0; i < LANES; i++) begin
      st[i] = bypass_model[i] ? last_active[i] : (run_length[i] >= thr);
    end
    return st;
  endfunction

  // Applies one word to the model and returns the result it must produce.
  function automatic result_t debounce_step(logic op, logic [LANES-1:0] lv,
                                            logic [CHAN_W-1:0] ch);
    result_t            r;
    logic [LANES-1:0]   act;
    logic [LANES-1:0]   st;
    logic [COUNT_W-1:0] thr;
    r = '0;
    // A threshold register of zero behaves as a threshold of one.
    thr = (thr_model == '0) ? COUNT_W'(1) : COUNT_W'(thr_model);
    if (op == OP_TICK) begin
      act = lv ^ act_low_model;
      for (int i = 0; i < LANES; i++) begin
        if (act[i]) begin
          // The counter saturates one past the threshold.
          if (run_length[i] <= thr) run_length[i] = run_length[i] + 1'b1;
        end else begin
          run_length[i] = '0;
        end
        // Bypass channels flag a rise on the level edge itself; debounced
        // channels flag it on the tick where the run reaches the threshold.
        if (bypass_model[i]) begin
          if (act[i] && !last_active[i]) rise_model[i] = 1'b1;
        end else if (run_length[i] == thr) begin
          rise_model[i] = 1'b1;
        end
        if (act[i] != last_active[i]) change_model[i] = 1'b1;
      end
      last_active = act;
    end else if (ch < LANES) begin
      st = debounced_states();
      r.chan_state = st[ch[LANE_IDX_W-1:0]];
      r.chan_rise_event = rise_model[ch[LANE_IDX_W-1:0]];
      r.chan_change_event = change_model[ch[LANE_IDX_W-1:0]];
      rise_model[ch[LANE_IDX_W-1:0]] = 1'b0;
      change_model[ch[LANE_IDX_W-1:0]] = 1'b0;
    end
    // A read of a channel past the last one reports zeros and clears nothing.
    r.states = debounced_states();
    return r;
  endfunction

  function automatic void add_word(logic op, logic [LANES-1:0] lv, logic [CHAN_W-1:0] ch,
                                   bit typed = 1'b0, result_t want = '0);
    stim_row_t row;
    row.kind = ROW_WORD;
    row.op = op;
    row.levels = lv;
    row.channel = ch;
    row.typed = typed;
    row.want = want;
    row.reg_index = REG_ACTIVE_LOW;
    row.reg_value = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind = ROW_REG;
    row.op = OP_TICK;
    row.levels = '0;
    row.channel = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.reg_index = idx;
    row.reg_value = val;
    stim_rows.push_back(row);
  endfunction

  // Drops valid, waits until every outstanding result has been taken and then
  // starts a fresh burst for the next word.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  // Register writes happen only with the block idle. Each write holds the
  // enable high for a single cycle, then drops it, so back-to-back
  // writes never schedule two values on the enable in the same step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ACTIVE_LOW: act_low_model = val[LANES-1:0];
      REG_BYPASS:     bypass_model = val[LANES-1:0];
      REG_THRESHOLD:  thr_model = val[THR_W-1:0];
      default:        ;
    endcase
  endtask

  // Offers one word and waits for the block to take it. The sender works in
  // bursts: at a burst's end valid drops for a random gap if sender_gaps
  // is set. Within a burst valid stays high from word to word without being
  // touched twice in one step; the prediction is made at the acceptance edge.
  task automatic send_word(input logic op, input logic [LANES-1:0] lv,
                           input logic [CHAN_W-1:0] ch, input bit typed,
                           input result_t want);
    result_t predicted;
    if (burst_left == 0) begin
      if (sender_gaps) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.levels <= lv;
    req_ch.channel <= ch;
    do @(posedge clk); while (!req_ch.ready);
    predicted = debounce_step(op, lv, ch);
    pending_results.push_back(typed ? want : predicted);
    if (op == OP_TICK) tick_count++;
    else read_count++;
  endtask

  // Receiver: ready follows a rotating 16-bit pattern that is redrawn whenever
  // its random hold count runs out. Some patterns are all ones, giving stall-free stretches.
  initial begin
    logic [15:0] pattern;
    int          left;
    rsp_ch.ready = 1'b0;
    pattern = 16'hFFFF;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       pattern = 16'hFFFF;
          1:       pattern = 16'($urandom) | 16'h0001;
          default: pattern = (16'($urandom) & 16'($urandom)) | (16'h1 << $urandom_range(0, 15));
        endcase
      end
      left--;
      rsp_ch.ready <= pattern[0];
      pattern = {pattern[0], pattern[15:1]};
    end
  end

  // Every accepted result is checked field by field against the oldest
  // expectation. Values are sampled at the edge, before any update.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with none expected, states %h",
                                  rsp_ch.states));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (rsp_ch.states !== want.states)
          report_mismatch($sformatf("states got %h want %h", rsp_ch.states, want.states));
        if (rsp_ch.chan_state !== want.chan_state)
          report_mismatch($sformatf("chan_state got %b want %b",
                                    rsp_ch.chan_state, want.chan_state));
        if (rsp_ch.chan_rise_event !== want.chan_rise_event)
          report_mismatch($sformatf("chan_rise_event got %b want %b",
                                    rsp_ch.chan_rise_event, want.chan_rise_event));
        if (rsp_ch.chan_change_event !== want.chan_change_event)
          report_mismatch($sformatf("chan_change_event got %b want %b",
                                    rsp_ch.chan_change_event, want.chan_change_event));
      end
    end
  end

  initial begin
    logic [LANES-1:0]     held;
    logic [LANES-1:0]     lv;
    logic [CHAN_W-1:0]    ch;
    logic [THR_W-1:0]     thr;
    logic [CFG_DATA_W-1:0] al_val;
    logic [CFG_DATA_W-1:0] by_val;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_ACTIVE_LOW;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_TICK;
    req_ch.levels = '0;
    req_ch.channel = '0;

    act_low_model = '0;
    bypass_model = '0;
    thr_model = THRESHOLD_RESET;
    foreach (run_length[i]) run_length[i] = '0;
    rise_model = '0;
    change_model = '0;
    last_active = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the reset settings first. Reads right after reset
    // and reads past the last channel must come back as all zeros.
    add_word(OP_READ, '0, 6'd0, 1'b1, '0);
    add_word(OP_READ, '1, 6'd63, 1'b1, '0);
    add_word(OP_READ, 32'h1234_5678, 6'd32, 1'b1, '0);
    // Five all-active ticks: the run reaches the threshold of three on the
    // third, goes one past it on the fourth and holds there on the fifth.
    add_word(OP_TICK, '1, '0);
    add_word(OP_TICK, '1, '0);
    add_word(OP_TICK, '1, '0);
    add_word(OP_TICK, '1, '0);
    add_word(OP_TICK, '1, '0);
    // Reading twice shows the flags before and after clearing.
    add_word(OP_READ, '0, 6'd31);
    add_word(OP_READ, '0, 6'd31);
    add_word(OP_TICK, '0, '0);
    add_word(OP_READ, '1, 6'd0);
    // Threshold of one, then a threshold of zero that acts as one.
    add_reg(REG_THRESHOLD, 32'd1);
    add_word(OP_TICK, 32'h8000_0001, '0);
    add_word(OP_READ, '0, 6'd0);
    add_reg(REG_THRESHOLD, 32'd0);
    add_word(OP_TICK, 32'h0000_0001, '0);
    add_word(OP_TICK, '0, '0);
    add_word(OP_READ, '0, 6'd0);
    // Every channel active low and bypassed, at the largest threshold.
    add_reg(REG_BYPASS, '1);
    add_reg(REG_ACTIVE_LOW, '1);
    add_reg(REG_THRESHOLD, 32'd31);
    add_word(OP_TICK, '0, '0);
    add_word(OP_READ, '0, 6'd5);
    add_word(OP_TICK, '1, '0);
    add_word(OP_READ, '0, 6'd5);
    // Leave bypass: debouncing resumes from the counts kept meanwhile.
    add_reg(REG_BYPASS, '0);
    add_reg(REG_ACTIVE_LOW, 32'h0000_FFFF);
    add_word(OP_TICK, 32'hFFFF_0000, '0);
    add_word(OP_READ, '0, 6'd16);
    add_word(OP_READ, '0, 6'd63);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        write_reg(stim_rows[i].reg_index, stim_rows[i].reg_value);
      end else begin
        send_word(stim_rows[i].op, stim_rows[i].levels, stim_rows[i].channel,
                  stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random part: eight settings, the first four fixing some registers at their
    // extremes. Levels are mostly held steady so that runs can reach even large
    // thresholds, with sparse bounce on top and now and then a fully random word.
    held = $urandom;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin al_val = '0; by_val = '0; thr = 5'd1; end
        1: begin al_val = '1; by_val = '0; thr = 5'd31; end
        2: begin al_val = $urandom; by_val = '1; thr = 5'($urandom_range(1, 31)); end
        3: begin al_val = $urandom; by_val = '0; thr = 5'd0; end
        default: begin
          al_val = $urandom;
          by_val = $urandom & $urandom;
          thr = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(2, 6))
                                            : 5'($urandom_range(1, 31));
        end
      endcase
      write_reg(REG_ACTIVE_LOW, al_val);
      write_reg(REG_BYPASS, by_val);
      write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
      setting_count++;
      sender_gaps = ($urandom_range(0, 3) != 0);

      for (int n = 0; n < 225; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 39) == 0) held = held ^ ($urandom & $urandom);
          lv = held;
          if ($urandom_range(0, 3) == 0) lv = lv ^ ($urandom & $urandom & $urandom);
          if ($urandom_range(0, 19) == 0) lv = $urandom;
          send_word(OP_TICK, lv, 6'($urandom), 1'b0, '0);
        end else begin
          ch = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(32, 63))
                                           : 6'($urandom_range(0, 31));
          send_word(OP_READ, $urandom, ch, 1'b0, '0);
        end
      end
    end

    // Drain, then keep clocking the block so that any stray word shows.
    settle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d sample ticks and %0d channel reads over %0d random settings,",
             tick_count, read_count, setting_count);
    $display("with %0d result words compared field by field.", results_checked);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Timeout with %0d result words still outstanding", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
